// ----- rtl/qmr_pkg.sv -----
// Shared types and constants for the quaternion multiply and rotate block.
package qmr_pkg;

   localparam int unsigned QFRAC    = 12;
   localparam int unsigned NTERM    = 4;
   localparam int unsigned PIPE_LEN = 5;

   typedef logic signed [15:0] comp_type;
   typedef logic signed [16:0] opnd_type;
   typedef logic signed [33:0] prod_type;
   typedef logic signed [35:0] acc_type;
   typedef logic signed [23:0] rnd_type;

   localparam acc_type ROUND_HALF = 36'sd2048;
   localparam rnd_type CLIP_MAX   = 24'sd32767;
   localparam rnd_type CLIP_MIN   = -24'sd32768;

   typedef enum logic {
      CMD_PRODUCT = 1'b0,
      CMD_ROTATE  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic     command;
      comp_type a_w;
      comp_type a_x;
      comp_type a_y;
      comp_type a_z;
      comp_type b_w;
      comp_type b_x;
      comp_type b_y;
      comp_type b_z;
   } req_type;

   typedef struct packed {
      comp_type r_w;
      comp_type r_x;
      comp_type r_y;
      comp_type r_z;
      logic     saturated;
   } rsp_type;

   typedef struct packed {
      opnd_type w;
      opnd_type x;
      opnd_type y;
      opnd_type z;
   } quat17_type;

   typedef struct packed {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } quat_type;

   // Operands of one lane: four products, each optionally negated.
   typedef struct packed {
      opnd_type p0;
      opnd_type q0;
      opnd_type p1;
      opnd_type q1;
      opnd_type p2;
      opnd_type q2;
      opnd_type p3;
      opnd_type q3;
      logic [NTERM-1:0] neg;
   } lane_in_type;

   typedef struct packed {
      comp_type value;
      logic     clip;
   } lane_out_type;

   // Term signs per component: bit 0 is the first term.
   localparam logic [NTERM-1:0] NEG_W   = 4'b1110;
   localparam logic [NTERM-1:0] NEG_VEC = 4'b1000;

   function automatic opnd_type widen(input comp_type v);
      return {v[15], v};
   endfunction

   function automatic opnd_type negate(input comp_type v);
      return -{v[15], v};
   endfunction

endpackage

// ----- rtl/qmr_lane.sv -----
// One component lane: four products, then sum, round half up and clip to Q3.12.
module qmr_lane (
   input  logic                 clock,
   input  qmr_pkg::lane_in_type lane_in,
   output qmr_pkg::lane_out_type lane_out
);
   import qmr_pkg::*;

   prod_type     prod_ff [NTERM];
   prod_type     prod_in [NTERM];
   opnd_type     op_p    [NTERM];
   opnd_type     op_q    [NTERM];
   acc_type      sum;
   acc_type      sum_rnd;
   rnd_type      rnd;
   lane_out_type res_ff;
   lane_out_type res_in;

   always_comb begin
      op_p[0] = lane_in.p0;  op_q[0] = lane_in.q0;
      op_p[1] = lane_in.p1;  op_q[1] = lane_in.q1;
      op_p[2] = lane_in.p2;  op_q[2] = lane_in.q2;
      op_p[3] = lane_in.p3;  op_q[3] = lane_in.q3;
      for (int i = 0; i < NTERM; i++) begin
         prod_in[i] = op_p[i] * op_q[i];
         if (lane_in.neg[i]) begin
            prod_in[i] = -prod_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NTERM; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      res_ff <= res_in;
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < NTERM; i++) begin
         sum = sum + {{2{prod_ff[i][33]}}, prod_ff[i]};
      end
      sum_rnd = sum + ROUND_HALF;
      // floor of the division: drop the fraction bits of a two's complement value
      rnd = sum_rnd[35:QFRAC];
      priority if (rnd > CLIP_MAX) begin
         res_in.value = 16'sh7FFF;
         res_in.clip  = 1'b1;
      end else if (rnd < CLIP_MIN) begin
         res_in.value = -16'sh8000;
         res_in.clip  = 1'b1;
      end else begin
         res_in.value = rnd[15:0];
         res_in.clip  = 1'b0;
      end
   end

   assign lane_out = res_ff;

endmodule

// ----- rtl/qmr_hamilton.sv -----
// Hamilton product P*Q spread over four component lanes, registered after the products and after rounding.
module qmr_hamilton (
   input  logic                clock,
   input  qmr_pkg::quat17_type p,
   input  qmr_pkg::quat17_type q,
   output qmr_pkg::quat_type   r,
   output logic                clip
);
   import qmr_pkg::*;

   lane_in_type  lin  [NTERM];
   lane_out_type lout [NTERM];

   always_comb begin
      lin[0] = '{p0: p.w, q0: q.w, p1: p.x, q1: q.x, p2: p.y, q2: q.y,
                 p3: p.z, q3: q.z, neg: NEG_W};
      lin[1] = '{p0: p.w, q0: q.x, p1: p.x, q1: q.w, p2: p.y, q2: q.z,
                 p3: p.z, q3: q.y, neg: NEG_VEC};
      lin[2] = '{p0: p.w, q0: q.y, p1: p.y, q1: q.w, p2: p.z, q2: q.x,
                 p3: p.x, q3: q.z, neg: NEG_VEC};
      lin[3] = '{p0: p.w, q0: q.z, p1: p.z, q1: q.w, p2: p.x, q2: q.y,
                 p3: p.y, q3: q.x, neg: NEG_VEC};
   end

   for (genvar g = 0; g < NTERM; g++) begin : g_lane
      qmr_lane u_lane (
         .clock    (clock),
         .lane_in  (lin[g]),
         .lane_out (lout[g])
      );
   end

   assign r.w  = lout[0].value;
   assign r.x  = lout[1].value;
   assign r.y  = lout[2].value;
   assign r.z  = lout[3].value;
   assign clip = lout[0].clip | lout[1].clip | lout[2].clip | lout[3].clip;

endmodule

// ----- rtl/qmr_merge.sv -----
// Output stage: pick the first or second product and, for a rotation, combine the clip flags.
module qmr_merge (
   input  logic              clock,
   input  qmr_pkg::quat_type t,
   input  logic              t_clip,
   input  qmr_pkg::quat_type r,
   input  logic              r_clip,
   input  logic              command,
   output qmr_pkg::rsp_type  rsp
);
   import qmr_pkg::*;

   quat_type t_d_ff [2];
   logic     t_clip_ff [2];
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   always_comb begin
      unique case (cmd_type'(command))
         CMD_ROTATE: begin
            rsp_in.r_w       = r.w;
            rsp_in.r_x       = r.x;
            rsp_in.r_y       = r.y;
            rsp_in.r_z       = r.z;
            rsp_in.saturated = t_clip_ff[1] | r_clip;
         end
         CMD_PRODUCT: begin
            rsp_in.r_w       = t_d_ff[1].w;
            rsp_in.r_x       = t_d_ff[1].x;
            rsp_in.r_y       = t_d_ff[1].y;
            rsp_in.r_z       = t_d_ff[1].z;
            rsp_in.saturated = t_clip_ff[1];
         end
         default: rsp_in = '0;
      endcase
   end

   // hold the first product until the second one lines up with it
   always_ff @(posedge clock) begin
      t_d_ff[0]    <= t;
      t_d_ff[1]    <= t_d_ff[0];
      t_clip_ff[0] <= t_clip;
      t_clip_ff[1] <= t_clip_ff[0];
      rsp_ff       <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// ----- rtl/quaternion_multiply_rotate.sv -----
// Top level: quaternion Hamilton product and rotation, five-stage pipeline.
//
//   channel   ports                    handshake
//   request   start, busy, req_word    taken when start is high and busy is low
//   response  rsp_valid, rsp_word      one cycle strobe, no back pressure
//
// One word enters every cycle; busy is never raised.
// A word passes the first product (multiply, then sum and round), then the
// second product in the same way, then the output register.
// Each of the two product units has four lanes of four 17x17 multipliers.
// Synchronous reset clears the valid pipeline; words in flight are dropped.
module quaternion_multiply_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qmr_pkg::req_type req_word,
   output logic             rsp_valid,
   output qmr_pkg::rsp_type rsp_word
);
   import qmr_pkg::*;

   logic [PIPE_LEN-1:0] valid_ff;
   logic [PIPE_LEN-1:0] valid_in;
   logic [3:0]          cmd_ff;
   quat_type            b_ff [2];
   quat17_type          p1;
   quat17_type          q1;
   quat17_type          p2;
   quat17_type          q2;
   quat_type            t;
   quat_type            r;
   logic                t_clip;
   logic                r_clip;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[PIPE_LEN-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // advance command and B beside the datapath
   always_ff @(posedge clock) begin
      cmd_ff  <= {cmd_ff[2:0], req_word.command};
      b_ff[0] <= '{w: req_word.b_w, x: req_word.b_x, y: req_word.b_y, z: req_word.b_z};
      b_ff[1] <= b_ff[0];
   end

   always_comb begin
      p1.w = widen(req_word.a_w);
      p1.x = widen(req_word.a_x);
      p1.y = widen(req_word.a_y);
      p1.z = widen(req_word.a_z);
      q1.w = widen(req_word.b_w);
      unique case (cmd_type'(req_word.command))
         CMD_ROTATE: begin
            q1.x = negate(req_word.b_x);
            q1.y = negate(req_word.b_y);
            q1.z = negate(req_word.b_z);
         end
         CMD_PRODUCT: begin
            q1.x = widen(req_word.b_x);
            q1.y = widen(req_word.b_y);
            q1.z = widen(req_word.b_z);
         end
         default: begin
            q1.x = '0;
            q1.y = '0;
            q1.z = '0;
         end
      endcase
      p2.w = widen(b_ff[1].w);
      p2.x = widen(b_ff[1].x);
      p2.y = widen(b_ff[1].y);
      p2.z = widen(b_ff[1].z);
      q2.w = widen(t.w);
      q2.x = widen(t.x);
      q2.y = widen(t.y);
      q2.z = widen(t.z);
   end

   qmr_hamilton u_first (
      .clock (clock),
      .p     (p1),
      .q     (q1),
      .r     (t),
      .clip  (t_clip)
   );

   qmr_hamilton u_second (
      .clock (clock),
      .p     (p2),
      .q     (q2),
      .r     (r),
      .clip  (r_clip)
   );

   qmr_merge u_merge (
      .clock   (clock),
      .t       (t),
      .t_clip  (t_clip),
      .r       (r),
      .r_clip  (r_clip),
      .command (cmd_ff[3]),
      .rsp     (rsp_word)
   );

   assign rsp_valid = valid_ff[PIPE_LEN-1];

endmodule

// ----- test/quaternion_multiply_rotate_tb.sv -----
// Testbench for quaternion_multiply_rotate: directed table, then random words vs. a predictor.
`timescale 1ns / 1ps

module quaternion_multiply_rotate_tb;
   import qmr_pkg::*;

   localparam longint Q_MAX        = 32767;
   localparam longint Q_MIN        = -32768;
   localparam int     RANDOM_ITEMS = 1930;

   typedef struct {
      longint w;
      longint x;
      longint y;
      longint z;
   } wide_quat_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_word = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_word;

   rsp_type pending_quats[$];
   req_type dir_word[$];
   bit      dir_known[$];
   rsp_type dir_rsp[$];

   int n_product = 0;
   int n_rotate  = 0;
   int n_clipped = 0;
   int n_errors  = 0;
   bit burst     = 1'b0;

   quaternion_multiply_rotate u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   initial begin
      #200_000;
      $display("** quaternion_multiply_rotate: FAILED **");
      $finish;
   end

   // Q6.24 sum to Q3.12: add half an LSB, floor, then clip.
   function automatic longint round_to_q12(input longint s, inout bit clip);
      longint r;
      r = (s + (longint'(1) <<< (QFRAC - 1))) >>> QFRAC;
      if (r > Q_MAX) begin
         clip = 1'b1;
         return Q_MAX;
      end
      if (r < Q_MIN) begin
         clip = 1'b1;
         return Q_MIN;
      end
      return r;
   endfunction

   function automatic wide_quat_type quat_product(input wide_quat_type p,
                                                  input wide_quat_type q, inout bit clip);
      wide_quat_type r;
      r.w = round_to_q12(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z, clip);
      r.x = round_to_q12(p.w * q.x + q.w * p.x + p.y * q.z - p.z * q.y, clip);
      r.y = round_to_q12(p.w * q.y + q.w * p.y + p.z * q.x - p.x * q.z, clip);
      r.z = round_to_q12(p.w * q.z + q.w * p.z + p.x * q.y - p.y * q.x, clip);
      return r;
   endfunction

   function automatic rsp_type qmr_result(input req_type w);
      wide_quat_type a;
      wide_quat_type b;
      wide_quat_type bc;
      wide_quat_type t;
      wide_quat_type r;
      bit            clip;
      rsp_type       o;
      clip = 1'b0;
      a.w = longint'(w.a_w);
      a.x = longint'(w.a_x);
      a.y = longint'(w.a_y);
      a.z = longint'(w.a_z);
      b.w = longint'(w.b_w);
      b.x = longint'(w.b_x);
      b.y = longint'(w.b_y);
      b.z = longint'(w.b_z);
      if (w.command == CMD_ROTATE) begin
         // conjugate stays exact: -(-32768) is carried wide
         bc.w = b.w;
         bc.x = -b.x;
         bc.y = -b.y;
         bc.z = -b.z;
         t = quat_product(a, bc, clip);
         r = quat_product(b, t, clip);
      end else begin
         r = quat_product(a, b, clip);
      end
      o.r_w       = r.w[15:0];
      o.r_x       = r.x[15:0];
      o.r_y       = r.y[15:0];
      o.r_z       = r.z[15:0];
      o.saturated = clip;
      return o;
   endfunction

   function automatic req_type make_word(input cmd_type c, input int aw, input int ax,
                                         input int ay, input int az, input int bw,
                                         input int bx, input int by, input int bz);
      req_type w;
      w.command = c;
      w.a_w = comp_type'(aw);
      w.a_x = comp_type'(ax);
      w.a_y = comp_type'(ay);
      w.a_z = comp_type'(az);
      w.b_w = comp_type'(bw);
      w.b_x = comp_type'(bx);
      w.b_y = comp_type'(by);
      w.b_z = comp_type'(bz);
      return w;
   endfunction

   function automatic rsp_type make_rsp(input int rw, input int rx, input int ry, input int rz,
                                        input bit sat);
      rsp_type o;
      o.r_w       = comp_type'(rw);
      o.r_x       = comp_type'(rx);
      o.r_y       = comp_type'(ry);
      o.r_z       = comp_type'(rz);
      o.saturated = sat;
      return o;
   endfunction

   function automatic comp_type rand_comp();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = int'($urandom_range(0, 65535));
         4, 5, 6, 7: v = int'($urandom_range(0, 8192)) - 4096;
         default: begin
            case ($urandom_range(0, 5))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               3: v = 4096;
               4: v = -4096;
               default: v = -1;
            endcase
         end
      endcase
      return comp_type'(v);
   endfunction

   task automatic add_row(input req_type w, input bit known, input rsp_type r);
      dir_word.push_back(w);
      dir_known.push_back(known);
      dir_rsp.push_back(r);
   endtask

   // Hold the word until taken, then log what should come back.
   task automatic send_word(input req_type w, input bit known, input rsp_type r);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_quats.push_back(known ? r : qmr_result(w));
      if (w.command == CMD_ROTATE) n_rotate++;
      else n_product++;
   endtask

   // Drop start only when a gap follows, so back-to-back words keep it high.
   task automatic idle_gap();
      int gap;
      if ($urandom_range(0, 49) == 0) burst = ~burst;
      gap = burst ? 0 : int'($urandom_range(0, 12));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_quats.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d (%h), got %0d (%h)", $time, name,
                  $signed(want), want, $signed(got), got);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_quats.size() == 0) begin
            $display("%0t ns: unexpected result word %h", $time, rsp_word);
            n_errors++;
         end else begin
            want = pending_quats.pop_front();
            check_field("r_w", want.r_w, rsp_word.r_w);
            check_field("r_x", want.r_x, rsp_word.r_x);
            check_field("r_y", want.r_y, rsp_word.r_y);
            check_field("r_z", want.r_z, rsp_word.r_z);
            check_field("saturated", {15'd0, want.saturated}, {15'd0, rsp_word.saturated});
            if (rsp_word.saturated === 1'b1) n_clipped++;
         end
      end
   end

   initial begin : stimulus
      req_type w;
      rsp_type none;
      none = '0;

      // zeros, identities, clipping at both rails, half-LSB rounding
      add_row(make_word(CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, make_rsp(0, 0, 0, 0, 0));
      add_row(make_word(CMD_PRODUCT, 4096, 0, 0, 0, 4096, 0, 0, 0), 1'b1,
              make_rsp(4096, 0, 0, 0, 0));
      add_row(make_word(CMD_PRODUCT, 0, 4096, 0, 0, 0, 0, 4096, 0), 1'b1,
              make_rsp(0, 0, 0, 4096, 0));
      add_row(make_word(CMD_PRODUCT, -32768, 0, 0, 0, -32768, 0, 0, 0), 1'b1,
              make_rsp(32767, 0, 0, 0, 1));
      add_row(make_word(CMD_PRODUCT, 32767, 0, 0, 0, -32768, 0, 0, 0), 1'b1,
              make_rsp(-32768, 0, 0, 0, 1));
      add_row(make_word(CMD_PRODUCT, 1, 0, 0, 0, 2048, 0, 0, 0), 1'b1,
              make_rsp(1, 0, 0, 0, 0));
      add_row(make_word(CMD_PRODUCT, -1, 0, 0, 0, 2048, 0, 0, 0), 1'b1,
              make_rsp(0, 0, 0, 0, 0));
      add_row(make_word(CMD_ROTATE, 0, 4096, 0, 0, 4096, 0, 0, 0), 1'b1,
              make_rsp(0, 4096, 0, 0, 0));
      // everything below goes through the predictor
      add_row(make_word(CMD_PRODUCT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
              1'b0, none);
      add_row(make_word(CMD_PRODUCT, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768), 1'b0, none);
      add_row(make_word(CMD_PRODUCT, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, none);
      add_row(make_word(CMD_PRODUCT, 21845, -21846, 21845, -21846,
                        -21846, 21845, -21846, 21845), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 0, 4096, 0, 0, 0, -32768, 0, 0), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 0, 100, 200, 300, 0, -32768, -32768, -32768), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 0, 4096, 0, 0, 2896, 0, 0, 2896), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 4096, 1000, -2000, 3000, 2896, 0, 0, 2896), 1'b0, none);
      add_row(make_word(CMD_ROTATE, -32768, 0, 0, 0, 4096, 0, 0, 0), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 4096, 4096, 4096, 4096, 0, 0, -32768, -32768), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767), 1'b0, none);
      add_row(make_word(CMD_ROTATE, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768, -32768), 1'b0, none);
      add_row(make_word(CMD_ROTATE, 0, 8192, -8192, 4096, 1448, 1448, 1448, 1448), 1'b0, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < dir_word.size(); i++) begin
         send_word(dir_word[i], dir_known[i], dir_rsp[i]);
         idle_gap();
      end
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         w.command = 1'($urandom_range(0, 1));
         w.a_w = rand_comp();
         w.a_x = rand_comp();
         w.a_y = rand_comp();
         w.a_z = rand_comp();
         w.b_w = rand_comp();
         w.b_x = rand_comp();
         w.b_y = rand_comp();
         w.b_z = rand_comp();
         send_word(w, 1'b0, none);
         // hold off midway until the pipeline is empty
         if (i == RANDOM_ITEMS / 2) drain();
         else idle_gap();
      end

      drain();
      repeat (PIPE_LEN + 3) @(posedge clock);

      $display("Covered %0d products and %0d rotations, %0d directed; %0d saturated results.",
               n_product, n_rotate, dir_word.size(), n_clipped);
      $display("Mismatches: %0d, results still outstanding: %0d.", n_errors,
               pending_quats.size());
      if (n_errors == 0 && pending_quats.size() == 0) begin
         $display("** quaternion_multiply_rotate: PASSED **");
      end else begin
         $display("** quaternion_multiply_rotate: FAILED **");
      end
      $finish;
   end

endmodule

// ----- quaternion_multiply_rotate.f -----
rtl/qmr_pkg.sv
rtl/qmr_lane.sv
rtl/qmr_hamilton.sv
rtl/qmr_merge.sv
rtl/quaternion_multiply_rotate.sv
test/quaternion_multiply_rotate_tb.sv
